// File: src/relay_thermostat_controller_defines.svh
// ----------------------------------------------------------------------------
// Relay thermostat controller assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RELAY_THERMOSTAT_CONTROLLER_DEFINES_SVH
`define RELAY_THERMOSTAT_CONTROLLER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rtc_pkg.sv
// ----------------------------------------------------------------------------
// Relay thermostat controller package
// Widths, request and mode codes, register map and per-relay action type.
// ----------------------------------------------------------------------------
package rtc_pkg;

  localparam int TIME_W         = 48;
  localparam int TEMP_FRAC_BITS = 4;
  localparam int TEMP_W         = 12;
  localparam int THR_W          = 8;
  localparam int LOCK_W         = 24;
  localparam int ADDR_W         = 5;
  localparam int DATA_W         = 32;

  localparam int SCALED_W = THR_W + TEMP_FRAC_BITS;
  localparam int CMP_W    = (TEMP_W > SCALED_W) ? TEMP_W : SCALED_W;

  localparam logic [LOCK_W-1:0] LOCKOUT_RESET = LOCK_W'(250000);
  localparam logic [THR_W-1:0]  LOWER_RESET   = THR_W'(20);
  localparam logic [THR_W-1:0]  UPPER_RESET   = THR_W'(22);

  typedef enum logic [2:0] {
    REQ_KEY_DOWN = 3'd0,
    REQ_KEY_UP   = 3'd1,
    REQ_PRESS    = 3'd2,
    REQ_OFF      = 3'd3,
    REQ_ON       = 3'd4,
    REQ_TOGGLE   = 3'd5,
    REQ_TEMP     = 3'd6
  } req_t;

  typedef enum logic [2:0] {
    MODE_DIRECT = 3'd0,
    MODE_FOLLOW = 3'd1,
    MODE_NOTIFY = 3'd2,
    MODE_HEAT   = 3'd3,
    MODE_COOL   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    REG_REVERSE  = 3'd0,
    REG_MODE1    = 3'd1,
    REG_MODE2    = 3'd2,
    REG_LOWER1   = 3'd3,
    REG_UPPER1   = 3'd4,
    REG_LOWER2   = 3'd5,
    REG_UPPER2   = 3'd6,
    REG_LOCKOUT  = 3'd7
  } reg_idx_t;

  // Requested action of one logical relay before the lockout check.
  typedef struct packed {
    logic want;
    logic val;
    logic notify;
  } relay_act_t;

endpackage

// File: src/relay_thermostat_controller.sv
// ----------------------------------------------------------------------------
// Relay thermostat controller
// Two-relay controller with button modes, remote commands and thermostats.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one event per transaction: a
// button key down, key up or press, a remote off/on/toggle command, or a
// temperature sample, each with the current microsecond time. Every input
// transaction produces exactly one result transaction on the out_ channel
// with both physical pin levels and the written, blocked and notify flags.
// An accepted event is first held in the input register and is then evaluated
// into the result register, which drives out_valid. Throughput is one
// transaction per cycle while the receiver does not stall; it is set by the
// relay state loop, where the 48-bit lockout compare and the pin update are
// computed combinationally.
// When the receiver stalls, the result register holds and the input register
// fills, after which in_stall rises until the result is taken.
// Reset clears both relays to off, the last write times to zero and loads
// the register defaults (lockout 250000 us, thresholds 20 and 22 degrees).
// Registers are written through the cfg_ APB port at byte address 4*index
// and must only be changed while no transaction is in flight.
// ----------------------------------------------------------------------------
`include "relay_thermostat_controller_defines.svh"

module relay_thermostat_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_req_type,
  input  logic                        in_channel,
  input  logic signed [11:0]          in_temperature,
  input  logic [rtc_pkg::TIME_W-1:0]  in_now_us,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_relay1_pin,
  output logic                        out_relay2_pin,
  output logic [1:0]                  out_written_mask,
  output logic [1:0]                  out_blocked_mask,
  output logic                        out_notify_press,
  // configuration port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [rtc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [rtc_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [rtc_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import rtc_pkg::*;

  // configuration registers
  logic                     reverse_r;
  mode_t                    mode_r  [2];
  logic signed [THR_W-1:0]  lower_r [2];
  logic signed [THR_W-1:0]  upper_r [2];
  logic [LOCK_W-1:0]        lockout_r;

  // relay state
  logic [1:0]               pin_r,  pin_nxt;
  logic [TIME_W-1:0]        last_r [2];
  logic [TIME_W-1:0]        last_nxt [2];

  // input register
  logic                     s1_valid_r;
  req_t                     s1_req_r;
  logic                     s1_chan_r;
  logic signed [TEMP_W-1:0] s1_temp_r;
  logic [TIME_W-1:0]        s1_now_r;

  // result register
  logic                     out_valid_r;
  logic [1:0]               out_pin_r;
  logic [1:0]               out_wr_r, wr_nxt;
  logic [1:0]               out_blk_r, blk_nxt;
  logic                     out_notify_r, notify_nxt;

  logic                     adv_out;
  logic                     in_fire;
  logic                     s1_fire;
  logic                     cfg_wr;
  reg_idx_t                 cfg_idx;

  assign adv_out  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv_out;
  assign in_fire  = in_valid && !in_stall;
  assign s1_fire  = s1_valid_r && adv_out;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Action that one logical relay asks for, before the lockout check.
  function automatic relay_act_t relay_eval(
    input req_t                    req,
    input logic                    sel,
    input mode_t                   mode,
    input logic                    cur,
    input logic signed [CMP_W-1:0] t,
    input logic signed [CMP_W-1:0] lo,
    input logic signed [CMP_W-1:0] hi
  );
    relay_act_t a;
    a = '0;
    unique case (req)
      REQ_KEY_DOWN, REQ_KEY_UP: begin
        if (sel && mode == MODE_FOLLOW) begin
          a.want = 1'b1;
          a.val  = !cur;
        end
      end
      REQ_PRESS: begin
        if (sel && mode == MODE_DIRECT) begin
          a.want = 1'b1;
          a.val  = !cur;
        end else if (sel && mode == MODE_NOTIFY) begin
          a.notify = 1'b1;
        end
      end
      REQ_OFF: begin
        a.want = sel && cur;
        a.val  = 1'b0;
      end
      REQ_ON: begin
        a.want = sel && !cur;
        a.val  = 1'b1;
      end
      REQ_TOGGLE: begin
        a.want = sel;
        a.val  = !cur;
      end
      REQ_TEMP: begin
        // The upper threshold is tested first; the lower only below it.
        if (mode == MODE_HEAT) begin
          if (t >= hi) begin
            a.want = cur;
            a.val  = 1'b0;
          end else if (t <= lo) begin
            a.want = !cur;
            a.val  = 1'b1;
          end
        end else if (mode == MODE_COOL) begin
          if (t >= hi) begin
            a.want = !cur;
            a.val  = 1'b1;
          end else if (t <= lo) begin
            a.want = cur;
            a.val  = 1'b0;
          end
        end
      end
      default: a = '0;
    endcase
    return a;
  endfunction

  // Relay evaluation. Both logical relays map onto different pins, so they
  // are independent within one transaction.
  always_comb begin
    relay_act_t              act;
    logic                    idx;
    logic                    pidx;
    logic                    cur;
    logic                    past_boot;
    logic                    too_soon;
    logic [TIME_W-1:0]       elapsed;
    logic [TIME_W-1:0]       lock_ext;
    logic signed [CMP_W-1:0] t_s;
    logic signed [CMP_W-1:0] lo_s;
    logic signed [CMP_W-1:0] hi_s;
    pin_nxt    = pin_r;
    last_nxt   = last_r;
    wr_nxt     = '0;
    blk_nxt    = '0;
    notify_nxt = 1'b0;
    lock_ext   = TIME_W'(lockout_r);
    past_boot  = s1_now_r >= lock_ext;
    t_s        = CMP_W'(s1_temp_r);
    for (int r = 0; r < 2; r++) begin
      idx      = 1'(r);
      pidx     = idx ^ reverse_r;
      cur      = pin_r[pidx];
      lo_s     = CMP_W'(lower_r[idx]) <<< TEMP_FRAC_BITS;
      hi_s     = CMP_W'(upper_r[idx]) <<< TEMP_FRAC_BITS;
      act      = relay_eval(s1_req_r, s1_chan_r == idx, mode_r[idx], cur, t_s, lo_s, hi_s);
      elapsed  = s1_now_r - last_r[idx];
      too_soon = (s1_now_r < last_r[idx]) || (elapsed < lock_ext);
      if (act.notify) begin
        notify_nxt = 1'b1;
      end
      if (act.want && past_boot && too_soon) begin
        blk_nxt[idx] = 1'b1;
      end else if (act.want) begin
        pin_nxt[pidx] = act.val;
        last_nxt[idx] = s1_now_r;
        wr_nxt[idx]   = 1'b1;
      end
    end
  end

  // Pipeline and relay state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pin_r       <= '0;
      last_r[0]   <= '0;
      last_r[1]   <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (adv_out) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        pin_r  <= pin_nxt;
        last_r <= last_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r  <= req_t'(in_req_type);
      s1_chan_r <= in_channel;
      s1_temp_r <= in_temperature;
      s1_now_r  <= in_now_us;
    end
    if (s1_fire) begin
      out_pin_r    <= pin_nxt;
      out_wr_r     <= wr_nxt;
      out_blk_r    <= blk_nxt;
      out_notify_r <= notify_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_r  <= 1'b0;
      mode_r[0]  <= MODE_DIRECT;
      mode_r[1]  <= MODE_DIRECT;
      lower_r[0] <= LOWER_RESET;
      upper_r[0] <= UPPER_RESET;
      lower_r[1] <= LOWER_RESET;
      upper_r[1] <= UPPER_RESET;
      lockout_r  <= LOCKOUT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_REVERSE: reverse_r  <= cfg_pwdata[0];
        REG_MODE1:   mode_r[0]  <= mode_t'(cfg_pwdata[2:0]);
        REG_MODE2:   mode_r[1]  <= mode_t'(cfg_pwdata[2:0]);
        REG_LOWER1:  lower_r[0] <= cfg_pwdata[THR_W-1:0];
        REG_UPPER1:  upper_r[0] <= cfg_pwdata[THR_W-1:0];
        REG_LOWER2:  lower_r[1] <= cfg_pwdata[THR_W-1:0];
        REG_UPPER2:  upper_r[1] <= cfg_pwdata[THR_W-1:0];
        REG_LOCKOUT: lockout_r  <= cfg_pwdata[LOCK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_REVERSE: cfg_prdata = DATA_W'(reverse_r);
      REG_MODE1:   cfg_prdata = DATA_W'(mode_r[0]);
      REG_MODE2:   cfg_prdata = DATA_W'(mode_r[1]);
      REG_LOWER1:  cfg_prdata = DATA_W'($unsigned(lower_r[0]));
      REG_UPPER1:  cfg_prdata = DATA_W'($unsigned(upper_r[0]));
      REG_LOWER2:  cfg_prdata = DATA_W'($unsigned(lower_r[1]));
      REG_UPPER2:  cfg_prdata = DATA_W'($unsigned(upper_r[1]));
      REG_LOCKOUT: cfg_prdata = DATA_W'(lockout_r);
      default:     cfg_prdata = '0;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_relay1_pin   = out_pin_r[0];
  assign out_relay2_pin   = out_pin_r[1];
  assign out_written_mask = out_wr_r;
  assign out_blocked_mask = out_blk_r;
  assign out_notify_press = out_notify_r;

  // A relay is either written or refused, never both.
  `RTC_ASSERT_NOW(a_wr_blk_disjoint, out_valid_r, (out_wr_r & out_blk_r) == 2'b00,
                  "relay both written and blocked")
  // A notify press never switches or refuses a relay.
  `RTC_ASSERT_NOW(a_notify_quiet, out_valid_r && out_notify_r,
                  out_wr_r == 2'b00 && out_blk_r == 2'b00, "notify press moved a relay")
  // Pins only move on a transaction that reports a write.
  `RTC_ASSERT_NEXT(a_pin_hold, !s1_fire || wr_nxt == 2'b00, pin_r == $past(pin_r),
                   "relay pin changed without a write")
  // Backpressure only arises with a full input register.
  `RTC_ASSERT_NOW(a_stall_full, in_stall, s1_valid_r, "input stalled while empty")

endmodule
